[hw/rtl/rpa_pkg.sv]
// shared types and constants of the reference-counted page allocator
`timescale 1ns / 1ps

package rpa_pkg;

    localparam int ADDR_W = 32;              // byte address width
    localparam int OFF_W  = 12;              // offset within a 4 KiB page
    localparam int PAGE_W = ADDR_W - OFF_W;  // page number width
    localparam int END_W  = PAGE_W + 1;      // end page and watermark width
    localparam int SPAN_W = END_W + 1;       // differences with a sign bit
    localparam int CNT_W  = 8;               // reference count width
    localparam int OP_W   = 3;
    localparam int STAT_W = 3;
    localparam int CFG_IDX_W = 1;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_PAGE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_PAGE   = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_INIT  = 3'd0,
        OP_ALLOC = 3'd1,
        OP_FREE  = 3'd2,
        OP_INC   = 3'd3,
        OP_QUERY = 3'd4
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_BAD_ADDR = 3'd1,
        ST_NO_PAGE  = 3'd2,
        ST_SHARED   = 3'd3,
        ST_SAT      = 3'd4,
        ST_FULL     = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } t_state;

    // where an alloc takes its page from
    typedef enum logic [1:0] {
        SRC_NONE,
        SRC_POP,
        SRC_WM
    } t_src;

endpackage

[hw/rtl/rpa_ram.sv]
// simple dual-port synchronous ram with registered read data
`timescale 1ns / 1ps

module rpa_ram #(
    parameter int  DATA_W = 8,
    parameter int  DEPTH  = 2,
    localparam int AW     = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [AW-1:0]     i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [AW-1:0]     i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hw/rtl/refcounted_page_allocator.sv]
// top level of the reference-counted page allocator
`timescale 1ns / 1ps

// Page allocator for 4 KiB pages in the range [first_page, top), where top is
// end_page clipped to first_page + MAX_PAGES. Every managed page carries an
// 8-bit reference count held in a synchronous ram; freed pages sit on a lifo
// stack in a second ram, and pages not yet handed out since init come from a
// descending watermark, so the highest page goes first. Ops: init, alloc,
// free, increment and query; each transaction on the input gives exactly one
// result transaction. An item goes through an accept cycle, which issues the
// ram reads (count at the page index, stack top at depth - 1), and an execute
// cycle, which does the modify and write-back and loads the output register.
// The execute cycle waits while an earlier result is still held in the output
// register; a new item can be accepted while a result waits. After reset the
// count ram is swept to zero, one entry per cycle, and no item is accepted
// during the sweep; configuration writes are taken at any time but must only
// be issued while the block is idle.
module refcounted_page_allocator #(
    parameter int MAX_PAGES = 32768
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [rpa_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rpa_pkg::END_W-1:0]        i_cfg_data,
    // operation channel
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [rpa_pkg::OP_W-1:0]         i_op,
    input  logic [rpa_pkg::ADDR_W-1:0]       i_addr,
    // result channel
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [rpa_pkg::STAT_W-1:0]       o_status,
    output logic [rpa_pkg::ADDR_W-1:0]       o_page_addr,
    output logic [rpa_pkg::CNT_W-1:0]        o_ref_count
);

    import rpa_pkg::*;

    localparam int IW = $clog2(MAX_PAGES);       // page index width
    localparam int DW = $clog2(MAX_PAGES + 1);   // stack depth width

    // configuration registers
    logic [PAGE_W-1:0] r_first_page;
    logic [END_W-1:0]  r_end_page;

    // allocator state
    t_state            r_state, n_state;
    logic [DW-1:0]     r_depth, n_depth;
    logic [END_W-1:0]  r_wm, n_wm;
    logic [IW-1:0]     r_clr_addr;

    // accepted item
    logic [OP_W-1:0]   r_op;
    logic              r_ok;
    logic [IW-1:0]     r_idx;
    t_src              r_src;

    // result register
    logic              r_out_valid;
    t_status           r_status;
    logic [ADDR_W-1:0] r_page_addr;
    logic [CNT_W-1:0]  r_ref_count;

    // fsm outputs
    logic              w_in_ready;
    logic              w_clearing;
    logic              w_exec_go;
    logic              w_accept;

    // managed range
    logic [SPAN_W-1:0] w_span;
    logic [END_W-1:0]  w_top;

    // accept-side decode
    logic [PAGE_W-1:0] w_page;
    logic              w_in_range;
    logic              w_aligned;
    logic              w_ok;
    logic [IW-1:0]     w_idx;
    logic [SPAN_W-1:0] w_wm_diff;
    logic              w_wm_ok;
    t_src              w_src;
    logic [END_W-1:0]  w_wm_m1;

    // execute-side results
    t_status           e_status;
    logic [ADDR_W-1:0] e_page_addr;
    logic [CNT_W-1:0]  e_count;

    // ram ports
    logic              cnt_we;
    logic [IW-1:0]     cnt_waddr;
    logic [CNT_W-1:0]  cnt_wdata;
    logic [CNT_W-1:0]  cnt_rdata;
    logic              x_cnt_we;
    logic [IW-1:0]     x_cnt_addr;
    logic [CNT_W-1:0]  x_cnt_data;
    logic              stk_we;
    logic [IW-1:0]     stk_waddr;
    logic [IW-1:0]     stk_wdata;
    logic [IW-1:0]     stk_raddr;
    logic [IW-1:0]     stk_rdata;

    //--------------------------------------------------------------------
    // configuration port, always ready
    //--------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_page <= '0;
            r_end_page   <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FIRST_PAGE: r_first_page <= i_cfg_data[PAGE_W-1:0];
                CFG_END_PAGE:   r_end_page   <= i_cfg_data;
            endcase
        end
    end

    // top = end_page clipped to first_page + MAX_PAGES, first_page when empty
    assign w_span = {1'b0, r_end_page} - SPAN_W'(r_first_page);

    always_comb begin
        if (r_end_page <= END_W'(r_first_page)) begin
            w_top = END_W'(r_first_page);
        end else if (w_span > SPAN_W'(MAX_PAGES)) begin
            w_top = END_W'(r_first_page) + END_W'(MAX_PAGES);
        end else begin
            w_top = r_end_page;
        end
    end

    //--------------------------------------------------------------------
    // control fsm
    //--------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == IW'(MAX_PAGES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_in_ready = 1'b0;
        w_clearing = 1'b0;
        w_exec_go  = 1'b0;
        unique case (r_state)
            S_CLEAR: w_clearing = 1'b1;
            S_IDLE:  w_in_ready = 1'b1;
            // execute only once the output register is free
            S_EXEC:  w_exec_go  = !r_out_valid || i_out_ready;
            default: ;
        endcase
    end

    assign o_in_ready = w_in_ready;
    assign w_accept   = i_in_valid && w_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (w_clearing) begin
                r_clr_addr <= r_clr_addr + IW'(1);
            end
        end
    end

    //--------------------------------------------------------------------
    // accept cycle: range check, index, alloc source, ram reads
    //--------------------------------------------------------------------
    assign w_page     = i_addr[ADDR_W-1:OFF_W];
    assign w_aligned  = (i_addr[OFF_W-1:0] == '0);
    assign w_in_range = ({1'b0, w_page} >= END_W'(r_first_page)) &&
                        ({1'b0, w_page} < w_top);
    assign w_idx      = IW'(w_page - r_first_page);
    assign w_ok       = w_in_range && ((t_op'(i_op) != OP_FREE) || w_aligned);

    // the watermark is usable only while it lies inside the managed window
    assign w_wm_diff  = {1'b0, r_wm} - SPAN_W'(r_first_page);
    assign w_wm_ok    = (r_wm > END_W'(r_first_page)) &&
                        (w_wm_diff <= SPAN_W'(MAX_PAGES));

    always_comb begin
        if (r_depth != '0) begin
            w_src = SRC_POP;
        end else if (w_wm_ok) begin
            w_src = SRC_WM;
        end else begin
            w_src = SRC_NONE;
        end
    end

    assign stk_raddr = IW'(r_depth - DW'(1));

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op  <= i_op;
            r_ok  <= w_ok;
            r_idx <= w_idx;
            r_src <= w_src;
        end
    end

    //--------------------------------------------------------------------
    // execute cycle: modify, write back, form the result
    //--------------------------------------------------------------------
    assign w_wm_m1 = r_wm - END_W'(1);

    always_comb begin
        logic [IW-1:0]     v_idx;
        logic [PAGE_W-1:0] v_page;
        logic [CNT_W-1:0]  v_cnt;

        v_idx       = '0;
        v_page      = '0;
        v_cnt       = '0;
        n_depth     = r_depth;
        n_wm        = r_wm;
        x_cnt_we    = 1'b0;
        x_cnt_addr  = r_idx;
        x_cnt_data  = '0;
        stk_we      = 1'b0;
        stk_waddr   = r_depth[IW-1:0];
        stk_wdata   = r_idx;
        e_status    = ST_OK;
        e_page_addr = '0;
        e_count     = '0;

        if (w_exec_go) begin
            unique case (t_op'(r_op))
                OP_INIT: begin
                    // counts are kept, only stack and watermark restart
                    n_depth = '0;
                    n_wm    = w_top;
                end
                OP_ALLOC: begin
                    case (r_src)
                        SRC_POP: begin
                            n_depth = r_depth - DW'(1);
                            v_idx   = stk_rdata;
                            v_page  = r_first_page + PAGE_W'(stk_rdata);
                        end
                        SRC_WM: begin
                            n_wm   = w_wm_m1;
                            v_idx  = IW'(w_wm_m1 - END_W'(r_first_page));
                            v_page = w_wm_m1[PAGE_W-1:0];
                        end
                        default: ;
                    endcase
                    if (r_src == SRC_NONE) begin
                        e_status = ST_NO_PAGE;
                    end else begin
                        x_cnt_we    = 1'b1;
                        x_cnt_addr  = v_idx;
                        x_cnt_data  = CNT_W'(1);
                        e_count     = CNT_W'(1);
                        e_page_addr = {v_page, OFF_W'(0)};
                    end
                end
                OP_FREE: begin
                    if (!r_ok) begin
                        e_status = ST_BAD_ADDR;
                    end else begin
                        // a count already at zero stays there (double free)
                        v_cnt      = (cnt_rdata != '0) ? cnt_rdata - CNT_W'(1) : '0;
                        x_cnt_we   = 1'b1;
                        x_cnt_data = v_cnt;
                        e_count    = v_cnt;
                        if (v_cnt != '0) begin
                            e_status = ST_SHARED;
                        end else if (r_depth < DW'(MAX_PAGES)) begin
                            stk_we  = 1'b1;
                            n_depth = r_depth + DW'(1);
                        end else begin
                            e_status = ST_FULL;
                        end
                    end
                end
                OP_INC: begin
                    if (!r_ok) begin
                        e_status = ST_BAD_ADDR;
                    end else if (cnt_rdata == CNT_MAX) begin
                        e_status = ST_SAT;
                        e_count  = CNT_MAX;
                    end else begin
                        x_cnt_we   = 1'b1;
                        x_cnt_data = cnt_rdata + CNT_W'(1);
                        e_count    = cnt_rdata + CNT_W'(1);
                    end
                end
                OP_QUERY: begin
                    if (!r_ok) begin
                        e_status = ST_BAD_ADDR;
                    end else begin
                        e_count = cnt_rdata;
                    end
                end
                default: ;  // unused op codes give an ok result and change nothing
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
            r_wm    <= '0;
        end else begin
            r_depth <= n_depth;
            r_wm    <= n_wm;
        end
    end

    // count ram write port: zeroing sweep after reset, then execute writes
    always_comb begin
        if (w_clearing) begin
            cnt_we    = 1'b1;
            cnt_waddr = r_clr_addr;
            cnt_wdata = '0;
        end else begin
            cnt_we    = x_cnt_we;
            cnt_waddr = x_cnt_addr;
            cnt_wdata = x_cnt_data;
        end
    end

    //--------------------------------------------------------------------
    // result register
    //--------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_exec_go) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_exec_go) begin
            r_status    <= e_status;
            r_page_addr <= e_page_addr;
            r_ref_count <= e_count;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_page_addr = r_page_addr;
    assign o_ref_count = r_ref_count;

    //--------------------------------------------------------------------
    // memories
    //--------------------------------------------------------------------
    rpa_ram #(
        .DATA_W (CNT_W),
        .DEPTH  (MAX_PAGES)
    ) u_count_ram (
        .i_clk     (i_clk),
        .i_wr_en   (cnt_we),
        .i_wr_addr (cnt_waddr),
        .i_wr_data (cnt_wdata),
        .i_rd_en   (w_accept),
        .i_rd_addr (w_idx),
        .o_rd_data (cnt_rdata)
    );

    rpa_ram #(
        .DATA_W (IW),
        .DEPTH  (MAX_PAGES)
    ) u_stack_ram (
        .i_clk     (i_clk),
        .i_wr_en   (stk_we),
        .i_wr_addr (stk_waddr),
        .i_wr_data (stk_wdata),
        .i_rd_en   (w_accept),
        .i_rd_addr (stk_raddr),
        .o_rd_data (stk_rdata)
    );

endmodule

[dv/refcounted_page_allocator_test.sv]
// self-checking testbench of the reference-counted page allocator
`timescale 1ns / 1ps

// Drives op transactions into the allocator and checks every result transaction
// against an in-order prediction. The predictor keeps its own copy of the
// register range, the per-page counts, the free stack and the watermark. Each
// accepted op is predicted at its accept edge and queued. Each result is
// popped and compared field by field. Directed tests come first: every op,
// the range extremes, bad addresses, double free, stale watermark and stale
// stack entries, and count saturation. Then come a long receiver stall and
// randomised traffic over many ranges.
module refcounted_page_allocator_test;

    import rpa_pkg::*;

    localparam int MAX_PAGES     = 32768;
    localparam int CLK_HALF      = 4;           // 8 ns period
    localparam int RESET_CYCLES  = 9;
    localparam int MAX_GAP       = 6;           // longest idle per transaction
    localparam int SETTLE_CYCLES = 16;          // quiet time once all results are in
    localparam int LONG_HOLD     = 400;         // receiver hold-off in cycles
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RANDOM_ROUNDS = 8;
    localparam int ROUND_ITEMS   = 100;
    localparam int MAX_SPAN      = 40;          // most pages in a short random range

    localparam int unsigned PAGE_MAX = (1 << PAGE_W) - 1;
    localparam int unsigned END_MAX  = 1 << PAGE_W;

    localparam logic [ADDR_W-1:0] OFF_MASK = (1 << OFF_W) - 1;

    // op codes the block ignores
    localparam logic [OP_W-1:0] OP_RSVD_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD_LAST  = 3'd7;

    typedef struct {
        logic [STAT_W-1:0] status;
        logic [ADDR_W-1:0] page_addr;
        logic [CNT_W-1:0]  ref_count;
    } t_outcome;

    // dut connections, inputs known from time zero
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_FIRST_PAGE;
    logic [END_W-1:0]     i_cfg_data  = '0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    logic [OP_W-1:0]      i_op        = OP_INIT;
    logic [ADDR_W-1:0]    i_addr      = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [STAT_W-1:0]    o_status;
    logic [ADDR_W-1:0]    o_page_addr;
    logic [CNT_W-1:0]     o_ref_count;

    refcounted_page_allocator #(
        .MAX_PAGES (MAX_PAGES)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_op        (i_op),
        .i_addr      (i_addr),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_status    (o_status),
        .o_page_addr (o_page_addr),
        .o_ref_count (o_ref_count)
    );

    // predicted allocator state
    int unsigned      base_page;                 // first managed page
    int unsigned      limit_page;                // one past the last page
    logic [CNT_W-1:0] page_refs [MAX_PAGES];
    int unsigned      free_pages [MAX_PAGES];
    int unsigned      stack_fill;
    int unsigned      fresh_mark;                // descending watermark

    t_outcome    awaited_results [$];           // predictions in issue order
    int unsigned live_pages [$];                // pages handed out, for well-formed frees
    int unsigned error_count  = 0;
    int unsigned cycle_count  = 0;

    // idling controls
    bit          tx_gaps_on   = 1'b1;
    bit          rx_stalls_on = 1'b1;
    int unsigned rx_gap       = 0;
    bit          rx_hold      = 1'b0;
    int unsigned hold_request = 0;

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    // top of the managed range, end page clipped to the count store size
    function automatic int unsigned range_top();
        if (limit_page <= base_page) begin
            return base_page;
        end
        if (limit_page - base_page > MAX_PAGES) begin
            return base_page + MAX_PAGES;
        end
        return limit_page;
    endfunction

    function automatic logic [ADDR_W-1:0] to_addr(input int unsigned page);
        return page << OFF_W;
    endfunction

    // applies one op to the predicted state and returns the result it gives
    function automatic t_outcome allocator_response(input logic [OP_W-1:0] op,
                                                    input logic [ADDR_W-1:0] addr);
        t_outcome    res;
        int unsigned page;
        int unsigned top;
        int unsigned slot;
        bit          managed;
        bit          found;
        res.status    = ST_OK;
        res.page_addr = '0;
        res.ref_count = '0;
        page    = addr >> OFF_W;
        top     = range_top();
        managed = (page >= base_page) && (page < top);
        slot    = page - base_page;
        found   = 1'b1;
        case (op)
            OP_INIT: begin
                // counts survive an init, only the stack and watermark restart
                stack_fill = 0;
                fresh_mark = top;
            end
            OP_ALLOC: begin
                if (stack_fill > 0) begin
                    // popped index is rebased on the current first page
                    stack_fill = stack_fill - 1;
                    slot = free_pages[stack_fill] % MAX_PAGES;
                end else if (fresh_mark > base_page &&
                             fresh_mark - 1 - base_page < MAX_PAGES) begin
                    fresh_mark = fresh_mark - 1;
                    slot = fresh_mark - base_page;
                end else begin
                    // also covers a watermark left outside a changed range
                    found = 1'b0;
                end
                if (found) begin
                    page_refs[slot] = CNT_W'(1);
                    res.ref_count   = CNT_W'(1);
                    res.page_addr   = to_addr(base_page + slot);
                end else begin
                    res.status = ST_NO_PAGE;
                end
            end
            OP_FREE: begin
                if (addr[OFF_W-1:0] != '0 || !managed) begin
                    res.status = ST_BAD_ADDR;
                end else begin
                    if (page_refs[slot] != '0) begin
                        page_refs[slot] = page_refs[slot] - 1'b1;
                    end
                    res.ref_count = page_refs[slot];
                    if (page_refs[slot] != '0) begin
                        res.status = ST_SHARED;
                    end else if (stack_fill < MAX_PAGES) begin
                        // a free of a zero count is pushed again
                        free_pages[stack_fill] = slot;
                        stack_fill = stack_fill + 1;
                    end else begin
                        res.status = ST_FULL;
                    end
                end
            end
            OP_INC: begin
                if (!managed) begin
                    res.status = ST_BAD_ADDR;
                end else begin
                    if (page_refs[slot] == CNT_MAX) begin
                        res.status = ST_SAT;
                    end else begin
                        page_refs[slot] = page_refs[slot] + 1'b1;
                    end
                    res.ref_count = page_refs[slot];
                end
            end
            OP_QUERY: begin
                if (!managed) begin
                    res.status = ST_BAD_ADDR;
                end else begin
                    res.ref_count = page_refs[slot];
                end
            end
            default: begin
                // reserved ops leave everything alone
            end
        endcase
        return res;
    endfunction

    // ---------------------------------------------------------------- drivers

    task automatic reset_block();
        int i;
        base_page  = 0;
        limit_page = 0;
        stack_fill = 0;
        fresh_mark = 0;
        for (i = 0; i < MAX_PAGES; i++) begin
            page_refs[i]  = '0;
            free_pages[i] = 0;
        end
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
    endtask

    // one op transaction; returns at the falling edge after acceptance with valid
    // still high, so a back-to-back transaction keeps it up
    task automatic send_item(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr);
        int unsigned gap;
        t_outcome    res;
        gap = tx_gaps_on ? $urandom_range(MAX_GAP, 0) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_addr     <= addr;
        do @(posedge i_clk); while (!o_in_ready);
        res = allocator_response(op, addr);
        awaited_results.push_back(res);
        if (op == OP_ALLOC && res.status == ST_OK) begin
            live_pages.push_back(res.page_addr >> OFF_W);
        end
        @(negedge i_clk);
    endtask

    // sender pause until every predicted result has been seen
    task automatic wait_all_results();
        i_in_valid <= 1'b0;
        while (awaited_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [END_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (index == CFG_FIRST_PAGE) begin
            base_page = 32'(data[PAGE_W-1:0]);
        end else begin
            limit_page = 32'(data);
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // only ever reprogrammed with the block idle
    task automatic set_range(input int unsigned first_word, input int unsigned limit);
        wait_all_results();
        write_reg(CFG_FIRST_PAGE, first_word[END_W-1:0]);
        write_reg(CFG_END_PAGE, limit[END_W-1:0]);
    endtask

    // page around the managed range, one either side of it included
    function automatic int unsigned near_page(input int unsigned span);
        return base_page - 1 + $urandom_range(span + 1, 0);
    endfunction

    function automatic int unsigned live_or_near(input int unsigned span);
        if (live_pages.size() > 0 && $urandom_range(3, 0) != 0) begin
            return live_pages[$urandom_range(live_pages.size() - 1, 0)];
        end
        return near_page(span);
    endfunction

    // ---------------------------------------------------------------- tests

    task automatic test_basic_ops();
        int i;
        // nothing to hand out before the first init
        send_item(OP_ALLOC, '0);
        send_item(OP_RSVD_LAST, '1);
        set_range(16, 24);
        send_item(OP_INIT, '0);
        send_item(OP_ALLOC, '0);                          // highest page first
        send_item(OP_ALLOC, '0);
        send_item(OP_QUERY, to_addr(23) | OFF_MASK);      // offset bits ignored
        send_item(OP_INC, to_addr(23));
        send_item(OP_FREE, to_addr(23));                  // still shared
        send_item(OP_FREE, to_addr(23));
        send_item(OP_FREE, to_addr(23));                  // double free, pushed again
        send_item(OP_FREE, to_addr(22) | 32'h800);        // misaligned
        send_item(OP_FREE, to_addr(15));                  // below the range
        send_item(OP_INC, to_addr(24));                   // at the top
        send_item(OP_QUERY, '1);
        send_item(OP_ALLOC, '0);                          // pops from the stack
        send_item(OP_ALLOC, '0);
        for (i = 0; i < 7; i++) begin
            send_item(OP_ALLOC, '0);                      // drains the watermark
        end
    endtask

    task automatic test_range_extremes();
        // single page at the very top of the address space
        set_range(PAGE_MAX, END_MAX);
        send_item(OP_INIT, '0);
        send_item(OP_ALLOC, '0);
        send_item(OP_ALLOC, '0);
        send_item(OP_QUERY, to_addr(PAGE_MAX) | OFF_MASK);
        send_item(OP_FREE, to_addr(PAGE_MAX));
        // whole space, clipped to the count store
        set_range(0, END_MAX);
        send_item(OP_INIT, '0);
        send_item(OP_ALLOC, '0);
        send_item(OP_QUERY, to_addr(MAX_PAGES));
        send_item(OP_FREE, to_addr(MAX_PAGES - 1));
        // empty range
        set_range(100, 0);
        send_item(OP_INIT, '0);
        send_item(OP_ALLOC, '0);
        send_item(OP_QUERY, to_addr(100));
    endtask

    task automatic test_stale_state();
        // pushed index rebased on a new first page
        set_range(16, 24);
        send_item(OP_INIT, '0);
        send_item(OP_ALLOC, '0);
        send_item(OP_FREE, to_addr(23));
        set_range(100, 200);
        send_item(OP_ALLOC, '0);
        send_item(OP_ALLOC, '0);                          // watermark below the range
        // watermark too far above a lowered first page; top bit of the write dropped
        set_range(40000, 40010);
        send_item(OP_INIT, '0);
        wait_all_results();
        write_reg(CFG_FIRST_PAGE, END_W'(END_MAX));
        send_item(OP_ALLOC, '0);
    endtask

    task automatic test_count_saturation();
        set_range(16, 24);
        send_item(OP_INIT, '0);
        send_item(OP_ALLOC, '0);
        repeat (int'(CNT_MAX)) send_item(OP_INC, to_addr(23));   // last one saturates
        send_item(OP_QUERY, to_addr(23));
        send_item(OP_FREE, to_addr(23));
    endtask

    task automatic test_backpressure();
        int i;
        set_range(16, 24);
        tx_gaps_on = 1'b0;
        send_item(OP_INIT, '0);
        // receiver holds off while ops keep coming, so the input stalls
        hold_request = LONG_HOLD;
        for (i = 0; i < 16; i++) begin
            send_item((i % 2 == 0) ? OP_ALLOC : OP_QUERY, to_addr(16 + i % 8));
        end
        tx_gaps_on = 1'b1;
        wait_all_results();
    endtask

    task automatic test_random_traffic();
        int          round;
        int          n;
        int          pick;
        int          k;
        int unsigned first;
        int unsigned limit;
        int unsigned span;
        int unsigned page;
        logic [OP_W-1:0] op;
        for (round = 0; round < RANDOM_ROUNDS; round++) begin
            first = $urandom_range(PAGE_MAX, 0);
            case ($urandom_range(7, 0))
                0: begin
                    first = 0;
                    limit = END_MAX;
                end
                1: limit = $urandom_range(first, 0);
                default: begin
                    limit = first + $urandom_range(MAX_SPAN, 1);
                    if (limit > END_MAX) begin
                        limit = END_MAX;
                    end
                end
            endcase
            // junk in the unused top bit of the first page write
            set_range(first | ($urandom_range(1, 0) << PAGE_W), limit);
            span = range_top() - base_page;
            live_pages.delete();
            tx_gaps_on   = (round % 4 != 1);
            rx_stalls_on = (round % 4 != 2);
            send_item(OP_INIT, $urandom);
            for (n = 1; n < ROUND_ITEMS; n++) begin
                pick = $urandom_range(99, 0);
                if (pick < 30) begin
                    send_item(OP_ALLOC, $urandom);
                end else if (pick < 55) begin
                    if (live_pages.size() > 0) begin
                        k = $urandom_range(live_pages.size() - 1, 0);
                        page = live_pages[k];
                        live_pages.delete(k);
                    end else begin
                        page = near_page(span);
                    end
                    send_item(OP_FREE, to_addr(page));
                end else if (pick < 68) begin
                    page = live_or_near(span);
                    live_pages.push_back(page);
                    send_item(OP_INC, to_addr(page) | ($urandom & OFF_MASK));
                end else if (pick < 79) begin
                    page = live_or_near(span);
                    send_item(OP_QUERY, to_addr(page) | ($urandom & OFF_MASK));
                end else if (pick < 82) begin
                    send_item(OP_INIT, $urandom);
                end else if (pick < 88) begin
                    op = OP_W'($urandom_range(OP_RSVD_LAST, OP_RSVD_FIRST));
                    send_item(op, $urandom);
                end else if (pick < 95) begin
                    op = OP_W'($urandom_range(OP_QUERY, OP_FREE));
                    send_item(op, $urandom);
                end else begin
                    page = near_page(span);
                    send_item(OP_FREE, to_addr(page) | $urandom_range(OFF_MASK, 1));
                end
            end
        end
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
    endtask

    // ---------------------------------------------------------------- checking

    function automatic void check_field(input string what, input logic [ADDR_W-1:0] want,
                                        input logic [ADDR_W-1:0] got);
        if (got !== want) begin
            $display("%0t mismatch %s: expected %0h, actual %0h", $time, what, want, got);
            error_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (awaited_results.size() == 0) begin
                $display("%0t unexpected result transaction: status %0d, page %0h, count %0d",
                         $time, o_status, o_page_addr, o_ref_count);
                error_count++;
            end else begin
                want = awaited_results.pop_front();
                check_field("status", ADDR_W'(want.status), ADDR_W'(o_status));
                check_field("page_addr", want.page_addr, o_page_addr);
                check_field("ref_count", ADDR_W'(want.ref_count), ADDR_W'(o_ref_count));
            end
            rx_gap = rx_stalls_on ? $urandom_range(MAX_GAP, 0) : 0;
        end
    end

    // result side ready, gap drawn per transaction
    always @(negedge i_clk) begin
        if (rx_hold || rx_gap > 0) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
        if (!rx_hold && rx_gap > 0) begin
            rx_gap = rx_gap - 1;
        end
    end

    // long receiver hold-off, counted here in cycles
    initial begin
        forever begin
            wait (hold_request != 0);
            @(posedge i_clk);
            rx_hold = 1'b1;
            repeat (hold_request) @(posedge i_clk);
            rx_hold      = 1'b0;
            hold_request = 0;
        end
    end

    // watchdog, sized well above the slowest correct run
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        reset_block();
        test_basic_ops();
        test_range_extremes();
        test_stale_state();
        test_count_saturation();
        test_backpressure();
        test_random_traffic();
        wait_all_results();
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
